// ===== rtl/core/bilinear_grid_interpolator_macros.svh =====
// Assertion macros for the interpolator checker.
`ifndef BILINEAR_GRID_INTERPOLATOR_MACROS_SVH
`define BILINEAR_GRID_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define BGI_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("bgi assertion failed");

// Next-cycle implication, masked while reset is high.
`define BGI_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("bgi assertion failed");

// Next-cycle implication that also holds across reset.
`define BGI_ASSERT_NEXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("bgi assertion failed");

`endif

// ===== rtl/core/bgi_pkg.sv =====
// Shared opcodes, register indexes, and saturation helper for the interpolator.
`timescale 1ns / 1ps
package bgi_pkg;

  localparam logic [1:0] OP_LOAD_X = 2'd0;
  localparam logic [1:0] OP_LOAD_Y = 2'd1;
  localparam logic [1:0] OP_LOAD_Z = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic CFG_X_POINTS_USED = 1'b0;
  localparam logic CFG_Y_POINTS_USED = 1'b1;

  typedef struct packed {
    logic              hit;
    logic signed [31:0] val;
  } sat_t;

  // Clip a 50-bit signed value to 32 bits.
  function automatic sat_t sat32(input logic signed [49:0] v);
    sat_t r;
    if (v > 50'sd2147483647) begin
      r.hit = 1'b1;
      r.val = 32'sh7FFFFFFF;
    end else if (v < -50'sd2147483648) begin
      r.hit = 1'b1;
      r.val = 32'sh80000000;
    end else begin
      r.hit = 1'b0;
      r.val = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/bilinear_grid_interpolator.sv =====
// Bilinear interpolator over a non-uniform Q16.16 grid, iterative datapath.
`timescale 1ns / 1ps
// Loads (x, y, z table writes) never raise busy.
// A query's done strobe follows a search of each axis (entries examined per axis:
// 1..used count), a divide and the lerp steps; a zero-width interval skips the divide.
// One query in flight; busy drops with done, so the next transaction can go on that edge.
// Synchronous active-high reset clears the sequencer and sets both counts to 16;
// table contents are not cleared and must be loaded before use.
module bilinear_grid_interpolator
  import bgi_pkg::*;
#(
  parameter int X_POINTS = 16,
  parameter int Y_POINTS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // command side
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [3:0]         x_index,
  input  logic [3:0]         y_index,
  input  logic signed [31:0] load_value,
  input  logic signed [31:0] query_x,
  input  logic signed [31:0] query_y,
  // result side
  output logic               done,
  output logic signed [31:0] interp_value,
  output logic               div_fault,
  output logic               saturated,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [4:0]         cfg_data
);

  localparam int XAW  = (X_POINTS > 1) ? $clog2(X_POINTS) : 1;
  localparam int YAW  = (Y_POINTS > 1) ? $clog2(Y_POINTS) : 1;
  localparam int ZD   = X_POINTS * Y_POINTS;
  localparam int ZAW  = $clog2(ZD);
  localparam int XCAP = (X_POINTS < 16) ? X_POINTS : 16;
  localparam int YCAP = (Y_POINTS < 16) ? Y_POINTS : 16;
  localparam logic [4:0] XCAP5 = 5'(XCAP);
  localparam logic [4:0] YCAP5 = 5'(YCAP);
  localparam logic [8:0] XP9   = 9'(X_POINTS);
  localparam logic [8:0] YP9   = 9'(Y_POINTS);
  localparam logic [16:0] XP17 = 17'(X_POINTS);

  typedef enum logic [4:0] {
    S_IDLE, S_SRCH, S_RLO, S_RHI, S_CAPH, S_DSET, S_DIVI, S_DFIN, S_AXEND,
    S_Z0, S_Z1, S_Z2, S_Z3, S_Z4, S_M0, S_A0, S_M1, S_A1, S_M2, S_A2
  } state_t;

  state_t state;

  // configuration
  logic [4:0] x_used, y_used;

  // query context
  logic signed [31:0] qx, qy;
  logic               ax;        // 0: x axis, 1: y axis
  logic [4:0]         cnt;
  logic               dv;        // search read data valid
  logic [3:0]         hi_idx, xh, yh;
  logic signed [31:0] lo_v, hi_v;
  logic signed [31:0] fr, lx, ly;
  logic               fault, satf;

  // divider
  logic [48:0]        nq;
  logic [32:0]        dm, rem;
  logic               neg;
  logic [5:0]         dcnt;

  // lerp
  logic signed [31:0] za, zb, zc, zd, r0, r1;
  logic signed [64:0] prod;

  // RAM ports
  logic [31:0] x_rd, y_rd, z_rd;
  logic        acc, x_we, y_we, z_we;
  logic [8:0]  xi9, yi9, ridx9;
  logic [4:0]  ridx;
  logic [16:0] zw17, zr17;
  logic [3:0]  zrow, zcol;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign acc       = start && !busy;

  assign xi9  = {5'b0, x_index};
  assign yi9  = {5'b0, y_index};
  assign x_we = acc && (op == OP_LOAD_X) && (xi9 < XP9);
  assign y_we = acc && (op == OP_LOAD_Y) && (yi9 < YP9);
  assign z_we = acc && (op == OP_LOAD_Z) && (xi9 < XP9) && (yi9 < YP9);
  assign zw17 = 17'(y_index) * XP17 + 17'(x_index);

  // table read index: walk during search, then low and high breakpoint
  always_comb begin
    unique case (state)
      S_SRCH:  ridx = cnt;
      S_RLO:   ridx = {1'b0, hi_idx} - 5'd1;
      default: ridx = {1'b0, hi_idx};
    endcase
  end
  assign ridx9 = {4'b0, ridx};

  // z corner address: (row low/high, column low/high)
  always_comb begin
    unique case (state)
      S_Z0:    begin zrow = yh - 4'd1; zcol = xh - 4'd1; end
      S_Z1:    begin zrow = yh - 4'd1; zcol = xh;        end
      S_Z2:    begin zrow = yh;        zcol = xh - 4'd1; end
      default: begin zrow = yh;        zcol = xh;        end
    endcase
  end
  assign zr17 = 17'(zrow) * XP17 + 17'(zcol);

  bgi_ram #(.WIDTH(32), .DEPTH(X_POINTS)) u_x_ram (
    .clk(clk), .we(x_we), .waddr(xi9[XAW-1:0]), .wdata(load_value),
    .raddr(ridx9[XAW-1:0]), .rdata(x_rd)
  );

  bgi_ram #(.WIDTH(32), .DEPTH(Y_POINTS)) u_y_ram (
    .clk(clk), .we(y_we), .waddr(yi9[YAW-1:0]), .wdata(load_value),
    .raddr(ridx9[YAW-1:0]), .rdata(y_rd)
  );

  bgi_ram #(.WIDTH(32), .DEPTH(ZD)) u_z_ram (
    .clk(clk), .we(z_we), .waddr(zw17[ZAW-1:0]), .wdata(load_value),
    .raddr(zr17[ZAW-1:0]), .rdata(z_rd)
  );

  // per-axis view of the active table
  logic signed [31:0] tdata, qv;
  logic [4:0]         n_x, n_y, nn, jj, ii, hi_c;
  logic               lt, last;

  assign n_x = (x_used < 5'd2) ? 5'd2 : ((x_used > XCAP5) ? XCAP5 : x_used);
  assign n_y = (y_used < 5'd2) ? 5'd2 : ((y_used > YCAP5) ? YCAP5 : y_used);
  assign nn    = ax ? n_y : n_x;
  assign tdata = ax ? $signed(y_rd) : $signed(x_rd);
  assign qv    = ax ? qy : qx;
  assign jj    = cnt - 5'd1;
  assign lt    = qv < tdata;
  assign last  = (jj == nn - 5'd1);
  assign ii    = lt ? jj : nn;
  // clamp to the first or last interval so outside points extrapolate
  assign hi_c  = (ii == 5'd0) ? 5'd1 : ((ii == nn) ? nn - 5'd1 : ii);

  // fraction setup: (q - lo) * 2^16 / (hi - lo), sign-magnitude
  logic signed [32:0] num33, den33;
  logic signed [48:0] num49;
  logic [48:0]        nmag;
  assign num33 = 33'(qv) - 33'(lo_v);
  assign den33 = 33'(hi_v) - 33'(lo_v);
  assign num49 = {num33, 16'b0};
  assign nmag  = num49[48] ? 49'(-num49) : 49'(num49);

  // restoring divide step
  logic [33:0] rs;
  logic        qbit;
  assign rs   = {rem, nq[48]};
  assign qbit = (rs >= {1'b0, dm});

  logic signed [49:0] qsgn;
  sat_t               fsat;
  assign qsgn = neg ? -$signed({1'b0, nq}) : $signed({1'b0, nq});
  assign fsat = sat32(qsgn);

  // shared multiply and accumulate
  logic signed [32:0] ma;
  logic signed [31:0] mb, aa;
  logic signed [49:0] lsum;
  sat_t               lsat;

  always_comb begin
    unique case (state)
      S_M0:    ma = 33'(zb) - 33'(za);
      S_M1:    ma = 33'(zd) - 33'(zc);
      default: ma = 33'(r1) - 33'(r0);
    endcase
    mb = (state == S_M2) ? ly : lx;
    unique case (state)
      S_A0:    aa = za;
      S_A1:    aa = zc;
      default: aa = r0;
    endcase
  end
  // floor of product / 2^16 is an arithmetic shift
  assign lsum = 50'(aa) + 50'($signed(prod[64:16]));
  assign lsat = sat32(lsum);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      done      <= 1'b0;
      x_used    <= 5'd16;
      y_used    <= 5'd16;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_X_POINTS_USED) x_used <= cfg_data;
        else                                y_used <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (acc && op == OP_QUERY) begin
            qx    <= query_x;
            qy    <= query_y;
            ax    <= 1'b0;
            cnt   <= 5'd0;
            dv    <= 1'b0;
            fault <= 1'b0;
            satf  <= 1'b0;
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          cnt <= cnt + 5'd1;
          dv  <= 1'b1;
          if (dv && (lt || last)) begin
            hi_idx <= hi_c[3:0];
            state  <= S_RLO;
          end
        end
        S_RLO: state <= S_RHI;
        S_RHI: begin
          lo_v  <= tdata;
          state <= S_CAPH;
        end
        S_CAPH: begin
          hi_v  <= tdata;
          state <= S_DSET;
        end
        S_DSET: begin
          if (den33 == 33'sd0) begin
            fault <= 1'b1;
            fr    <= 32'sd0;
            state <= S_AXEND;
          end else begin
            nq    <= nmag;
            dm    <= den33[32] ? 33'(-den33) : 33'(den33);
            neg   <= num49[48] ^ den33[32];
            rem   <= 33'd0;
            dcnt  <= 6'd0;
            state <= S_DIVI;
          end
        end
        S_DIVI: begin
          rem  <= qbit ? 33'(rs - {1'b0, dm}) : rs[32:0];
          nq   <= {nq[47:0], qbit};
          dcnt <= dcnt + 6'd1;
          if (dcnt == 6'd48) state <= S_DFIN;
        end
        S_DFIN: begin
          fr    <= fsat.val;
          satf  <= satf | fsat.hit;
          state <= S_AXEND;
        end
        S_AXEND: begin
          if (!ax) begin
            lx    <= fr;
            xh    <= hi_idx;
            ax    <= 1'b1;
            cnt   <= 5'd0;
            dv    <= 1'b0;
            state <= S_SRCH;
          end else begin
            ly    <= fr;
            yh    <= hi_idx;
            state <= S_Z0;
          end
        end
        S_Z0: state <= S_Z1;
        S_Z1: begin za <= z_rd; state <= S_Z2; end
        S_Z2: begin zb <= z_rd; state <= S_Z3; end
        S_Z3: begin zc <= z_rd; state <= S_Z4; end
        S_Z4: begin zd <= z_rd; state <= S_M0; end
        S_M0: begin prod <= ma * mb; state <= S_A0; end
        S_A0: begin
          r0    <= lsat.val;
          satf  <= satf | lsat.hit;
          state <= S_M1;
        end
        S_M1: begin prod <= ma * mb; state <= S_A1; end
        S_A1: begin
          r1    <= lsat.val;
          satf  <= satf | lsat.hit;
          state <= S_M2;
        end
        S_M2: begin prod <= ma * mb; state <= S_A2; end
        S_A2: begin
          interp_value <= lsat.val;
          saturated    <= satf | lsat.hit;
          div_fault    <= fault;
          done         <= 1'b1;
          state        <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/bgi_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bgi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/bgi_checker.sv =====
// Port-level checker for the interpolator, bound to the top level.
`timescale 1ns / 1ps
`include "bilinear_grid_interpolator_macros.svh"
module bgi_checker
  import bgi_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic [1:0] op,
  input logic       done
);

  `BGI_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !busy && !done)
  `BGI_ASSERT_NEXT(a_query_busy, clk, rst, start && !busy && op == OP_QUERY, busy)
  `BGI_ASSERT_NEXT(a_load_no_busy, clk, rst, start && !busy && op != OP_QUERY, !busy && !done)
  `BGI_ASSERT_NOW(a_done_idle, clk, rst, done, !busy)
  `BGI_ASSERT_NOW(a_fall_done, clk, rst, $fell(busy), done)

endmodule

bind bilinear_grid_interpolator bgi_checker u_bgi_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .done(done)
);
